@@ rtl/core/itt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itt_pkg: shared types and constants of the three-channel interval timer
// Holds operation codes, controller states, the command and status structs
// that join the controller and the datapath, and BCD helper functions.
// ----------------------------------------------------------------------------
package itt_pkg;

    localparam int NumChannelsDefault   = 3;
    localparam int MaxTickCyclesDefault = 16;
    localparam int TickW                = 5;
    localparam int CountW               = 16;

    // Item operation codes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_GATE  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [1:0] PORT_CTRL = 2'd3;

    // Access mode codes.
    localparam logic [1:0] AM_LATCH = 2'd0;
    localparam logic [1:0] AM_LO    = 2'd1;
    localparam logic [1:0] AM_HI    = 2'd2;
    localparam logic [1:0] AM_LOHI  = 2'd3;

    localparam logic [15:0] BIN_WRAP = 16'hFFFF;
    localparam logic [15:0] BCD_WRAP = 16'd9999;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TSTART,
        ST_TSTEP,
        ST_TNEXT,
        ST_OUT
    } itt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;   // take the input item
        logic       exec;      // run a write, read or gate item
        logic       tick_init; // set up the pass budget of the current channel
        logic       tick_step; // one clock pass of the current channel
        logic       tick_done; // clear gate_rose of the current channel
        logic [1:0] chan;      // channel walked by a tick
    } itt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       is_tick;
        logic       tick_zero;
        logic       budget_zero;
        logic       loaded;
    } itt_stat_t;

    // Packed BCD digits to binary, weights 1, 10, 100, 1000.
    function automatic logic [15:0] bcd_to_bin(input logic [15:0] w);
        logic [15:0] d0, d1, d2, d3;
        d0 = {12'd0, w[3:0]};
        d1 = {12'd0, w[7:4]};
        d2 = {12'd0, w[11:8]};
        d3 = {12'd0, w[15:12]};
        return 16'(d0 + d1 * 16'd10 + d2 * 16'd100 + d3 * 16'd1000);
    endfunction

    // Binary count to four BCD digits, each digit taken modulo ten.
    // Each quotient comes from one reciprocal multiplication of the count,
    // exact over the whole 16-bit range.
    function automatic logic [15:0] bin_to_bcd(input logic [15:0] v);
        logic [32:0] p1, p2, p3, p4;
        logic [15:0] q1, q2, q3, q4;
        p1 = {17'd0, v} * 33'd52429;
        p2 = {17'd0, v} * 33'd83887;
        p3 = {17'd0, v} * 33'd67109;
        p4 = {17'd0, v} * 33'd107375;
        q1 = 16'(p1 >> 19);
        q2 = 16'(p2 >> 23);
        q3 = 16'(p3 >> 26);
        q4 = 16'(p4 >> 30);
        return {4'(q3 - q4 * 16'd10), 4'(q2 - q3 * 16'd10),
                4'(q1 - q2 * 16'd10), 4'(v - q1 * 16'd10)};
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/interval_timer_three_channel_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// interval_timer_three_channel_unit: three-channel programmable interval timer
// Stream front end around a controller and a counter datapath.
// ----------------------------------------------------------------------------
// Each input item is a port write, a port read, a gate change or a tick, and
// gives exactly one result item with the read byte and the three out levels.
// Items are handled one at a time. A write, read or gate item is captured,
// executed and handed to the result register; a tick of zero clocks is not
// executed. Any other tick walks the channels in turn: an unloaded channel is
// only set up, and a loaded one then runs clock passes until its budget is
// spent (a pass ends at each reload or terminal count, so a short count in
// square-wave mode makes up to twice MAX_TICK_CYCLES passes). The result
// register lets the next item be accepted while a result still waits.
module interval_timer_three_channel_unit
    import itt_pkg::*;
#(
    parameter int NUM_CHANNELS    = NumChannelsDefault,
    parameter int MAX_TICK_CYCLES = MaxTickCyclesDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: operation[1:0], port[3:2], wdata[11:4],
    // gate_level[12], tick_cycles[17:13], zero fill.
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: rdata[7:0], out0[8], out1[9], out2[10], zero fill.
    output logic [15:0]      m_tdata
);

    itt_cmd_t   cmd;
    itt_stat_t  stat;
    logic [7:0] rdata;
    logic [2:0] outs;
    logic       out_load;

    // The result register loads when the controller hands a result over.
    itt_ctrl #(.NUM_CHANNELS(NUM_CHANNELS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_load(out_load),
        .cmd(cmd), .stat(stat)
    );

    itt_dp #(.NUM_CHANNELS(NUM_CHANNELS), .MAX_TICK_CYCLES(MAX_TICK_CYCLES)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_operation(s_tdata[1:0]), .in_port(s_tdata[3:2]),
        .in_wdata(s_tdata[11:4]), .in_gate_level(s_tdata[12]),
        .in_tick_cycles(s_tdata[17:13]),
        .cmd(cmd), .stat(stat), .out_load(out_load),
        .rdata(rdata), .outs(outs)
    );

    assign m_tdata = {5'd0, outs, rdata};

endmodule
`default_nettype wire

@@ rtl/core/itt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itt_ctrl: controller of the interval timer
// Sequences one item: capture, execution or a per-channel tick walk, then
// the result handoff to the output register.
// ----------------------------------------------------------------------------
module itt_ctrl
    import itt_pkg::*;
#(
    parameter int NUM_CHANNELS = NumChannelsDefault
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic           out_load,
    output itt_cmd_t       cmd,
    input  wire itt_stat_t stat
);

    itt_state_t state_reg, state_next;
    logic [1:0] chan_reg, chan_next;
    logic       valid_reg, valid_next;

    // State, channel index and result valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            chan_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        valid_next = valid_reg;
        cmd        = '0;
        cmd.chan   = chan_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        if (valid_reg && out_ready) valid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.is_tick && !stat.tick_zero) begin
                    chan_next  = 2'd0;
                    state_next = ST_TSTART;
                end else begin
                    cmd.exec   = !stat.is_tick;
                    state_next = ST_OUT;
                end
            end
            ST_TSTART: begin
                cmd.tick_init = 1'b1;
                state_next    = stat.loaded ? ST_TSTEP : ST_TNEXT;
            end
            ST_TSTEP: begin
                if (stat.budget_zero) state_next = ST_TNEXT;
                else cmd.tick_step = 1'b1;
            end
            ST_TNEXT: begin
                cmd.tick_done = 1'b1;
                if (32'(chan_reg) == NUM_CHANNELS - 1) begin
                    state_next = ST_OUT;
                end else begin
                    chan_next  = 2'(chan_reg + 2'd1);
                    state_next = ST_TSTART;
                end
            end
            ST_OUT: begin
                if (!valid_reg || out_ready) begin
                    out_load   = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/itt_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itt_dp: datapath of the interval timer
// Per-channel counter state, control and data port logic, and one clock
// pass of a channel per tick step.
// ----------------------------------------------------------------------------
module itt_dp
    import itt_pkg::*;
#(
    parameter int NUM_CHANNELS    = NumChannelsDefault,
    parameter int MAX_TICK_CYCLES = MaxTickCyclesDefault
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [1:0] in_operation,
    input  wire logic [1:0] in_port,
    input  wire logic [7:0] in_wdata,
    input  wire logic       in_gate_level,
    input  wire logic [4:0] in_tick_cycles,
    input  wire itt_cmd_t   cmd,
    output itt_stat_t       stat,
    input  wire logic       out_load,
    output logic [7:0]      rdata,
    output logic [2:0]      outs
);

    localparam int MaxTw = $clog2(MAX_TICK_CYCLES + 1);
    localparam int BudW  = MaxTw + 1;

    logic [15:0] cnt_reg [3];
    logic [2:0]  rp_reg, bcd_reg, out_reg, gin_reg, grose_reg, tog_reg;
    logic [2:0]  mode_reg [3];
    logic [1:0]  am_reg [3];
    logic [15:0] rl_reg [3];
    logic [1:0]  rlp_reg [3];
    logic [15:0] wl_reg [3];
    logic [1:0]  wbc_reg [3];
    logic [1:0]  ld_reg [3];

    logic [1:0]  op_reg, port_reg;
    logic [7:0]  wd_reg;
    logic        gl_reg;
    logic [4:0]  tc_reg;
    logic [BudW-1:0] bud_reg;
    logic [7:0]  rd_reg, rd_out_reg;
    logic [2:0]  outs_out_reg;

    // Saturated tick count.
    logic [BudW-1:0] tc_sat;
    always_comb begin
        if (32'(tc_reg) > MAX_TICK_CYCLES) tc_sat = BudW'(MAX_TICK_CYCLES);
        else tc_sat = BudW'(tc_reg);
    end

    assign stat.is_tick     = (op_reg == OP_TICK);
    assign stat.tick_zero   = (tc_reg == 5'd0);
    assign stat.budget_zero = (bud_reg == '0);
    assign stat.loaded      = (ld_reg[cmd.chan] != 2'd0);

    // One clock pass of the current channel.
    logic [1:0]  ch;
    logic [15:0] cv, lv, cdn_cnt, wrap;
    logic [BudW-1:0] cdn_c, pass_bud, passed;
    logic        cdn_hit, p_load, p_rp_clr, p_grose_clr, p_out_we, p_out_v;
    logic        sq, ok;
    logic [15:0] p_cnt;
    always_comb begin
        ch   = cmd.chan;
        cv   = cnt_reg[ch];
        lv   = bcd_reg[ch] ? bcd_to_bin(wl_reg[ch]) : wl_reg[ch];
        wrap = bcd_reg[ch] ? BCD_WRAP : BIN_WRAP;
        // Count down by the remaining budget, with wrap on zero.
        passed = bud_reg;
        cdn_cnt = cv;
        if (cv == 16'd0) begin
            cdn_cnt = wrap;
            passed  = BudW'(bud_reg - 1'b1);
        end
        if (16'(passed) <= cdn_cnt && (BudW <= 16 || (passed >> 16) == '0)) begin
            cdn_cnt = 16'(cdn_cnt - 16'(passed));
            cdn_c   = '0;
        end else begin
            cdn_c   = BudW'(passed - BudW'(cdn_cnt));
            cdn_cnt = 16'd0;
        end
        cdn_hit = (cdn_cnt == 16'd0);
        // A pending reload holds the count and ends the pass.
        if (rp_reg[ch]) begin
            cdn_cnt = cv;
            cdn_hit = 1'b0;
            cdn_c   = '0;
        end

        p_load = 1'b0; p_rp_clr = 1'b0; p_grose_clr = 1'b0;
        p_out_we = 1'b0; p_out_v = 1'b0;
        p_cnt = cv; pass_bud = '0; ok = 1'b0;
        sq = (mode_reg[ch][1:0] == 2'b11);
        case (mode_reg[ch])
            3'd0: begin
                if (rp_reg[ch]) begin
                    p_load = 1'b1; p_out_we = 1'b1; p_out_v = 1'b0;
                    pass_bud = BudW'(bud_reg - 1'b1);
                end else if (gin_reg[ch]) begin
                    p_cnt = cdn_cnt; pass_bud = cdn_c;
                    if (cdn_hit) begin
                        p_out_we = 1'b1; p_out_v = 1'b1; ok = 1'b1;
                    end
                    if (!ok) pass_bud = '0;
                end
            end
            3'd1: begin
                if (grose_reg[ch]) begin
                    p_grose_clr = 1'b1; p_load = 1'b1; p_out_we = 1'b1;
                    pass_bud = BudW'(bud_reg - 1'b1);
                end else begin
                    p_cnt = cdn_cnt;
                    if (cdn_hit && !out_reg[ch]) begin
                        p_out_we = 1'b1; p_out_v = 1'b1; pass_bud = cdn_c;
                    end
                end
            end
            3'd4, 3'd5: begin
                p_out_we = 1'b1; p_out_v = 1'b1;
                if (mode_reg[ch] == 3'd4 ? rp_reg[ch] : grose_reg[ch]) begin
                    p_load = 1'b1; p_grose_clr = (mode_reg[ch] == 3'd5);
                    pass_bud = BudW'(bud_reg - 1'b1);
                end else if (mode_reg[ch] == 3'd5 || gin_reg[ch]) begin
                    p_cnt = cdn_cnt;
                    if (cdn_hit) begin
                        p_out_v = 1'b0; pass_bud = cdn_c;
                    end
                end
            end
            default: begin
                // Rate generator and square wave.
                if (!sq) begin
                    p_out_we = 1'b1; p_out_v = 1'b1;
                end else begin
                    p_out_v = out_reg[ch];
                end
                if (rp_reg[ch]) begin
                    p_load = 1'b1; pass_bud = BudW'(bud_reg - 1'b1);
                end else if (gin_reg[ch]) begin
                    if (grose_reg[ch]) begin
                        p_grose_clr = 1'b1; p_load = 1'b1;
                        pass_bud = BudW'(bud_reg - 1'b1);
                    end else begin
                        p_cnt = cdn_cnt;
                        if (cdn_hit) begin
                            p_load = 1'b1; p_out_we = 1'b1;
                            p_out_v = sq ? !out_reg[ch] : 1'b0;
                            pass_bud = cdn_c;
                        end
                    end
                end
            end
        endcase
        if (p_load) begin
            p_cnt = lv; p_rp_clr = 1'b1;
        end
    end

    // Port logic for the executed item.
    logic [1:0] ctl_sc, ctl_am, rb_ch;
    logic       rb_any;
    always_comb begin
        ctl_sc = wd_reg[7:6];
        ctl_am = wd_reg[5:4];
        rb_any = 1'b1; rb_ch = 2'd0;
        if (wd_reg[1]) rb_ch = 2'd0;
        else if (wd_reg[2]) rb_ch = 2'd1;
        else if (wd_reg[3]) rb_ch = 2'd2;
        else rb_any = 1'b0;
    end

    logic [15:0] lat_cnt [3];
    always_comb begin
        for (int k = 0; k < 3; k++)
            lat_cnt[k] = bcd_reg[k] ? bin_to_bcd(cnt_reg[k]) : cnt_reg[k];
    end

    // State update.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= in_operation; port_reg <= in_port; wd_reg <= in_wdata;
            gl_reg <= in_gate_level; tc_reg <= in_tick_cycles;
            rd_reg <= 8'd0;
        end
        if (out_load) begin
            rd_out_reg   <= rd_reg;
            outs_out_reg <= out_reg;
        end
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                cnt_reg[k] <= '0; mode_reg[k] <= '0; am_reg[k] <= '0;
                rl_reg[k] <= '0; rlp_reg[k] <= '0; wl_reg[k] <= '0;
                wbc_reg[k] <= '0; ld_reg[k] <= '0;
            end
            rp_reg <= '0; bcd_reg <= '0; out_reg <= '0; gin_reg <= '0;
            grose_reg <= '0; tog_reg <= '0; bud_reg <= '0;
        end else begin
            if (cmd.tick_init)
                bud_reg <= (mode_reg[cmd.chan][1:0] == 2'b11) ? BudW'(tc_sat << 1) : tc_sat;
            if (cmd.tick_step) begin
                cnt_reg[ch] <= p_cnt;
                bud_reg     <= pass_bud;
                if (p_rp_clr) rp_reg[ch] <= 1'b0;
                if (p_grose_clr) grose_reg[ch] <= 1'b0;
                if (p_out_we) out_reg[ch] <= p_out_v;
            end
            if (cmd.tick_done) grose_reg[cmd.chan] <= 1'b0;
            if (cmd.exec) begin
                case (op_reg)
                    OP_WRITE: begin
                        if (port_reg == PORT_CTRL) begin
                            if (ctl_sc == 2'd3) begin
                                if (rb_any && 32'(rb_ch) < NUM_CHANNELS
                                        && rlp_reg[rb_ch] == 2'd0) begin
                                    if (!wd_reg[5]) begin
                                        rl_reg[rb_ch]  <= lat_cnt[rb_ch];
                                        tog_reg[rb_ch] <= (am_reg[rb_ch] == AM_HI);
                                        rlp_reg[rb_ch] <= (am_reg[rb_ch] == AM_LOHI)
                                                          ? 2'd2 : 2'd1;
                                    end else if (!wd_reg[4]) begin
                                        rl_reg[rb_ch]  <= {8'd0, out_reg[rb_ch],
                                            rp_reg[rb_ch], am_reg[rb_ch],
                                            mode_reg[rb_ch], bcd_reg[rb_ch]};
                                        tog_reg[rb_ch] <= 1'b0;
                                        rlp_reg[rb_ch] <= 2'd1;
                                    end
                                end
                            end else if (32'(ctl_sc) < NUM_CHANNELS) begin
                                if (ctl_am == AM_LATCH) begin
                                    if (rlp_reg[ctl_sc] == 2'd0) begin
                                        rl_reg[ctl_sc]  <= lat_cnt[ctl_sc];
                                        tog_reg[ctl_sc] <= (am_reg[ctl_sc] == AM_HI);
                                        rlp_reg[ctl_sc] <= (am_reg[ctl_sc] == AM_LOHI)
                                                           ? 2'd2 : 2'd1;
                                    end
                                end else begin
                                    bcd_reg[ctl_sc]  <= wd_reg[0];
                                    am_reg[ctl_sc]   <= ctl_am;
                                    mode_reg[ctl_sc] <= wd_reg[3:1];
                                    rlp_reg[ctl_sc]  <= 2'd0;
                                    tog_reg[ctl_sc]  <= 1'b0;
                                    rl_reg[ctl_sc]   <= 16'd0;
                                    ld_reg[ctl_sc]   <= 2'd0;
                                    wbc_reg[ctl_sc]  <= 2'd0;
                                    wl_reg[ctl_sc]   <= 16'd0;
                                    rp_reg[ctl_sc]   <= 1'b1;
                                    out_reg[ctl_sc]  <= (wd_reg[3:1] != 3'd0);
                                end
                            end
                        end else if (32'(port_reg) < NUM_CHANNELS) begin
                            case (am_reg[port_reg])
                                AM_LO: begin
                                    wl_reg[port_reg][7:0] <= wd_reg;
                                    ld_reg[port_reg]  <= 2'(wbc_reg[port_reg] + 2'd1);
                                    wbc_reg[port_reg] <= 2'd0;
                                    rp_reg[port_reg]  <= 1'b1;
                                end
                                AM_HI: begin
                                    wl_reg[port_reg][15:8] <= wd_reg;
                                    ld_reg[port_reg]  <= 2'(wbc_reg[port_reg] + 2'd1);
                                    wbc_reg[port_reg] <= 2'd0;
                                    rp_reg[port_reg]  <= 1'b1;
                                end
                                AM_LOHI: begin
                                    if (wbc_reg[port_reg][0])
                                        wl_reg[port_reg][15:8] <= wd_reg;
                                    else
                                        wl_reg[port_reg][7:0] <= wd_reg;
                                    if (2'(wbc_reg[port_reg] + 2'd1) < 2'd2) begin
                                        wbc_reg[port_reg] <= 2'(wbc_reg[port_reg] + 2'd1);
                                    end else begin
                                        ld_reg[port_reg]  <= 2'(wbc_reg[port_reg] + 2'd1);
                                        wbc_reg[port_reg] <= 2'd0;
                                        rp_reg[port_reg]  <= 1'b1;
                                    end
                                end
                                default: begin
                                    ld_reg[port_reg]  <= wbc_reg[port_reg];
                                    wbc_reg[port_reg] <= 2'd0;
                                    rp_reg[port_reg]  <= 1'b1;
                                end
                            endcase
                        end
                    end
                    OP_READ: begin
                        if (port_reg != PORT_CTRL && 32'(port_reg) < NUM_CHANNELS) begin
                            if (rlp_reg[port_reg] != 2'd0) begin
                                rd_reg <= tog_reg[port_reg] ? rl_reg[port_reg][15:8]
                                                            : rl_reg[port_reg][7:0];
                                rlp_reg[port_reg] <= 2'(rlp_reg[port_reg] - 2'd1);
                            end else begin
                                case (am_reg[port_reg])
                                    AM_LO:   rd_reg <= cnt_reg[port_reg][7:0];
                                    AM_HI:   rd_reg <= cnt_reg[port_reg][15:8];
                                    AM_LOHI: rd_reg <= tog_reg[port_reg]
                                                       ? cnt_reg[port_reg][15:8]
                                                       : cnt_reg[port_reg][7:0];
                                    default: rd_reg <= 8'd0;
                                endcase
                            end
                            tog_reg[port_reg] <= !tog_reg[port_reg];
                        end
                    end
                    OP_GATE: begin
                        if (port_reg != PORT_CTRL && 32'(port_reg) < NUM_CHANNELS) begin
                            if (!gin_reg[port_reg] && gl_reg) grose_reg[port_reg] <= 1'b1;
                            gin_reg[port_reg] <= gl_reg;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign rdata = rd_out_reg;
    always_comb begin
        for (int k = 0; k < 3; k++)
            outs[k] = (k < NUM_CHANNELS) ? outs_out_reg[k] : 1'b0;
    end

endmodule
`default_nettype wire

@@ sim/interval_timer_three_channel_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_timer_three_channel_unit_test: stream test of the interval timer
// Drives write, read, gate and tick items into the timer, predicts every
// result item with a behavioral copy of the three counters, and checks each
// read byte and out level as it leaves the block.
// ----------------------------------------------------------------------------
module interval_timer_three_channel_unit_test;
    import itt_pkg::*;

    // Operating modes; modes six and seven alias rate and square wave.
    localparam bit [2:0] MODE_TC_INT    = 3'd0;
    localparam bit [2:0] MODE_ONE_SHOT  = 3'd1;
    localparam bit [2:0] MODE_RATE      = 3'd2;
    localparam bit [2:0] MODE_SQUARE    = 3'd3;
    localparam bit [2:0] MODE_SW_STROBE = 3'd4;

    // Control word fields.
    localparam bit [1:0] SC_READBACK  = 2'd3;
    localparam bit [7:0] RB_NO_COUNT  = 8'h20;
    localparam bit [7:0] RB_NO_STATUS = 8'h10;
    localparam bit [7:0] RB_CH0       = 8'h02;
    localparam bit [7:0] RB_CH1       = 8'h04;
    localparam bit [7:0] RB_CH2       = 8'h08;

    typedef struct {
        bit [7:0] rdata;
        bit [2:0] outs;
    } timer_result_t;

    // Timer state copy, expected results and the checks on them.
    class timer_scoreboard;
        timer_result_t expected_q[$];
        int            errors;
        bit [15:0] count_val[3];
        bit        reload_pend[3];
        bit        bcd[3];
        bit [2:0]  mode[3];
        bit [1:0]  access[3];
        bit        out_lvl[3];
        bit        gate_lvl[3];
        bit        gate_rise[3];
        bit [15:0] rd_latch[3];
        bit [1:0]  rd_latch_pend[3];
        bit        rd_toggle[3];
        bit [15:0] wr_latch[3];
        bit [1:0]  wr_count[3];
        bit [1:0]  loaded[3];

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void latch_status(int i);
            if (rd_latch_pend[i] != 0) return;
            rd_latch[i] = {8'd0, out_lvl[i], reload_pend[i], access[i], mode[i], bcd[i]};
            rd_toggle[i] = 0;
            rd_latch_pend[i] = 1;
        endfunction

        function void latch_count(int i);
            int unsigned w;
            w = count_val[i];
            if (rd_latch_pend[i] != 0) return;
            if (bcd[i])
                w = (w % 10) | (((w / 10) % 10) << 4) | (((w / 100) % 10) << 8)
                    | (((w / 1000) % 10) << 12);
            rd_latch[i] = w[15:0];
            rd_toggle[i] = 0;
            rd_latch_pend[i] = 1;
            if (access[i] == AM_HI) rd_toggle[i] = 1;
            else if (access[i] == AM_LOHI) rd_latch_pend[i] = 2;
        endfunction

        function void load_count(int i);
            int unsigned w;
            w = wr_latch[i];
            if (bcd[i])
                w = (w & 15) + 10 * ((w >> 4) & 15) + 100 * ((w >> 8) & 15)
                    + 1000 * ((w >> 12) & 15);
            count_val[i] = w[15:0];
            reload_pend[i] = 0;
        endfunction

        // Counts down by up to the budget c; c returns the part of the budget left over.
        function bit count_down(int i, inout int unsigned c);
            int unsigned passed, cnt;
            if (reload_pend[i]) begin
                c = 0;
                return 0;
            end
            passed = c;
            cnt = count_val[i];
            if (cnt == 0) begin
                cnt = bcd[i] ? 9999 : 16'hFFFF;
                passed--;
            end
            if (passed <= cnt) begin
                cnt -= passed;
                c = 0;
            end else begin
                c = passed - cnt;
                cnt = 0;
            end
            count_val[i] = cnt[15:0];
            return cnt == 0;
        endfunction

        // One clock pass of a channel.
        function void clock_pass(int i, inout int unsigned c);
            bit [2:0] m;
            bit       square;
            m = mode[i];
            if (m[2:1] == 2'b11) m = {1'b0, m[1:0]};
            case (m)
                MODE_TC_INT: begin
                    if (reload_pend[i]) begin
                        load_count(i);
                        out_lvl[i] = 0;
                        c--;
                        return;
                    end
                    if (gate_lvl[i] && count_down(i, c)) begin
                        out_lvl[i] = 1;
                        return;
                    end
                end
                MODE_ONE_SHOT: begin
                    if (gate_rise[i]) begin
                        gate_rise[i] = 0;
                        load_count(i);
                        out_lvl[i] = 0;
                        c--;
                        return;
                    end
                    if (count_down(i, c) && out_lvl[i] == 0) begin
                        out_lvl[i] = 1;
                        return;
                    end
                end
                MODE_RATE, MODE_SQUARE: begin
                    square = (m == MODE_SQUARE);
                    if (!square) out_lvl[i] = 1;
                    if (reload_pend[i]) begin
                        load_count(i);
                        c--;
                        return;
                    end
                    if (gate_lvl[i]) begin
                        if (gate_rise[i]) begin
                            gate_rise[i] = 0;
                            load_count(i);
                            c--;
                            return;
                        end
                        if (count_down(i, c)) begin
                            load_count(i);
                            out_lvl[i] = square ? !out_lvl[i] : 1'b0;
                            return;
                        end
                    end
                end
                MODE_SW_STROBE: begin
                    out_lvl[i] = 1;
                    if (reload_pend[i]) begin
                        load_count(i);
                        c--;
                        return;
                    end
                    if (gate_lvl[i] && count_down(i, c)) begin
                        out_lvl[i] = 0;
                        return;
                    end
                end
                default: begin
                    // Hardware-triggered strobe.
                    out_lvl[i] = 1;
                    if (gate_rise[i]) begin
                        gate_rise[i] = 0;
                        load_count(i);
                        c--;
                        return;
                    end
                    if (count_down(i, c)) begin
                        out_lvl[i] = 0;
                        return;
                    end
                end
            endcase
            c = 0;
        endfunction

        function void write_control(bit [7:0] d);
            bit [1:0] sc, am;
            int       i;
            sc = d[7:6];
            am = d[5:4];
            if (sc == SC_READBACK) begin
                if ((d & RB_CH0) != 0) i = 0;
                else if ((d & RB_CH1) != 0) i = 1;
                else if ((d & RB_CH2) != 0) i = 2;
                else return;
                if ((d & RB_NO_COUNT) == 0) latch_count(i);
                if ((d & RB_NO_STATUS) == 0) latch_status(i);
                return;
            end
            i = sc;
            if (am == AM_LATCH) begin
                latch_count(i);
                return;
            end
            bcd[i] = d[0];
            access[i] = am;
            mode[i] = d[3:1];
            rd_latch_pend[i] = 0;
            rd_toggle[i] = 0;
            rd_latch[i] = 0;
            loaded[i] = 0;
            wr_count[i] = 0;
            wr_latch[i] = 0;
            reload_pend[i] = 1;
            out_lvl[i] = (mode[i] != MODE_TC_INT);
        endfunction

        function void write_data(int i, bit [7:0] d);
            case (access[i])
                AM_LO: begin
                    wr_latch[i][7:0] = d;
                    wr_count[i]++;
                end
                AM_HI: begin
                    wr_latch[i][15:8] = d;
                    wr_count[i]++;
                end
                AM_LOHI: begin
                    if (wr_count[i][0]) wr_latch[i][15:8] = d;
                    else wr_latch[i][7:0] = d;
                    wr_count[i]++;
                    if (wr_count[i] < 2) return;
                end
                default: ;
            endcase
            loaded[i] = wr_count[i];
            wr_count[i] = 0;
            reload_pend[i] = 1;
        endfunction

        function bit [7:0] read_data(int i);
            bit [7:0] d;
            d = 0;
            if (rd_latch_pend[i] != 0) begin
                d = rd_toggle[i] ? rd_latch[i][15:8] : rd_latch[i][7:0];
                rd_latch_pend[i]--;
            end else if (access[i] == AM_LO) begin
                d = count_val[i][7:0];
            end else if (access[i] == AM_HI) begin
                d = count_val[i][15:8];
            end else if (access[i] == AM_LOHI) begin
                d = rd_toggle[i] ? count_val[i][15:8] : count_val[i][7:0];
            end
            rd_toggle[i] = !rd_toggle[i];
            return d;
        endfunction

        function void advance(int unsigned cycles);
            int unsigned c;
            if (cycles == 0) return;
            if (cycles > MaxTickCyclesDefault) cycles = MaxTickCyclesDefault;
            for (int i = 0; i < 3; i++) begin
                if (loaded[i] != 0) begin
                    c = (mode[i][1:0] == 2'b11) ? cycles * 2 : cycles;
                    while (c > 0) clock_pass(i, c);
                end
                gate_rise[i] = 0;
            end
        endfunction

        // An item was accepted: update the state copy and queue its result.
        function void note_input(bit [23:0] item);
            bit [1:0]      op, port;
            bit [7:0]      wd;
            timer_result_t r;
            op = item[1:0];
            port = item[3:2];
            wd = item[11:4];
            r.rdata = 0;
            case (op)
                OP_WRITE: begin
                    if (port == PORT_CTRL) write_control(wd);
                    else write_data(port, wd);
                end
                OP_READ: if (port != PORT_CTRL) r.rdata = read_data(port);
                OP_GATE: begin
                    if (port != PORT_CTRL) begin
                        if (!gate_lvl[port] && item[12]) gate_rise[port] = 1;
                        gate_lvl[port] = item[12];
                    end
                end
                default: advance(item[17:13]);
            endcase
            r.outs = {out_lvl[2], out_lvl[1], out_lvl[0]};
            expected_q.push_back(r);
        endfunction

        task check_result(bit [15:0] d);
            timer_result_t r;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result item %h", d));
                return;
            end
            r = expected_q.pop_front();
            if (d[7:0] != r.rdata)
                report($sformatf("rdata %h, predicted %h", d[7:0], r.rdata));
            for (int i = 0; i < 3; i++)
                if (d[8 + i] != r.outs[i])
                    report($sformatf("out%0d %b, predicted %b", i, d[8 + i], r.outs[i]));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    timer_scoreboard sb;
    int              burst_left;
    int              items_sent;
    logic [8:0]      rx_cycle = '0;

    interval_timer_three_channel_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 aclk = !aclk;
    end

    // Receiver alternates stretches of random stalls with always-ready ones.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1'b1;
        if (rx_cycle[8]) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Sends one item, opening a new burst after a random gap when due.
    task automatic send_item(input bit [1:0] op, input bit [1:0] port,
                             input bit [7:0] wd, input bit gl, input bit [4:0] tc);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, tc, gl, wd, port, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_input({6'd0, tc, gl, wd, port, op});
        items_sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic random_sequence;
        bit [1:0]  ch, am;
        bit [15:0] value;
        bit [7:0]  ctrl;
        ch = 2'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                // Program a channel and load a count, mostly a small one.
                am = 2'($urandom_range(1, 3));
                ctrl = {ch, am, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))};
                value = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 40));
                send_item(OP_WRITE, PORT_CTRL, ctrl, 1'($urandom), 5'($urandom));
                if (am == AM_HI) begin
                    send_item(OP_WRITE, ch, value[7:0], 1'($urandom), 5'($urandom));
                end else begin
                    send_item(OP_WRITE, ch, value[7:0], 1'($urandom), 5'($urandom));
                    if (am == AM_LOHI)
                        send_item(OP_WRITE, ch, value[15:8], 1'($urandom), 5'($urandom));
                end
            end
            3: begin
                send_item(OP_GATE, ch, 8'($urandom), 1'b0, 5'($urandom));
                send_item(OP_GATE, ch, 8'($urandom), 1'b1, 5'($urandom));
            end
            4, 5, 6: begin
                repeat ($urandom_range(1, 3))
                    send_item(OP_TICK, 2'($urandom), 8'($urandom), 1'($urandom),
                              5'($urandom_range(0, 31)));
            end
            7: begin
                // Counter latch of that channel or a readback with random selects, then reads.
                ctrl = ($urandom_range(0, 1) == 0) ? {ch, AM_LATCH, 4'($urandom)}
                       : {SC_READBACK, 2'($urandom), 3'($urandom), 1'($urandom)};
                send_item(OP_WRITE, PORT_CTRL, ctrl, 1'($urandom), 5'($urandom));
                repeat ($urandom_range(1, 3))
                    send_item(OP_READ, ch, 8'($urandom), 1'($urandom), 5'($urandom));
            end
            8: send_item(OP_READ, 2'($urandom), 8'($urandom), 1'($urandom), 5'($urandom));
            default:
                send_item(2'($urandom), 2'($urandom), 8'($urandom), 1'($urandom),
                          5'($urandom));
        endcase
    endtask

    initial begin
        #2ms;
        $display("interval_timer_three_channel_unit_test: done, errors");
        $finish;
    end

    initial begin
        sb = new;
        burst_left = 0;
        items_sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: reset-state write, control-port read and gate,
        // zero and oversize ticks, readback corners, BCD with bad digits.
        send_item(OP_WRITE, 2'd0, 8'h55, 1'b0, 5'd0);
        send_item(OP_READ, PORT_CTRL, 8'h00, 1'b0, 5'd0);
        send_item(OP_GATE, PORT_CTRL, 8'hFF, 1'b1, 5'd31);
        send_item(OP_TICK, 2'd0, 8'h00, 1'b0, 5'd0);
        send_item(OP_WRITE, PORT_CTRL, 8'hC0, 1'b0, 5'd0);
        send_item(OP_WRITE, PORT_CTRL, 8'h30, 1'b0, 5'd0);
        send_item(OP_WRITE, 2'd0, 8'h05, 1'b0, 5'd0);
        send_item(OP_WRITE, 2'd0, 8'h00, 1'b0, 5'd0);
        send_item(OP_GATE, 2'd0, 8'h00, 1'b1, 5'd0);
        send_item(OP_TICK, 2'd0, 8'h00, 1'b0, 5'd31);
        send_item(OP_WRITE, PORT_CTRL, 8'h00, 1'b0, 5'd0);
        send_item(OP_READ, 2'd0, 8'h00, 1'b0, 5'd0);
        send_item(OP_READ, 2'd0, 8'h00, 1'b0, 5'd0);
        send_item(OP_WRITE, PORT_CTRL, 8'h77, 1'b0, 5'd0);
        send_item(OP_WRITE, 2'd1, 8'hAB, 1'b0, 5'd0);
        send_item(OP_WRITE, 2'd1, 8'hFF, 1'b0, 5'd0);
        send_item(OP_GATE, 2'd1, 8'h00, 1'b1, 5'd0);
        send_item(OP_TICK, 2'd0, 8'h00, 1'b0, 5'd16);
        send_item(OP_WRITE, PORT_CTRL, 8'hCE, 1'b0, 5'd0);
        send_item(OP_READ, 2'd0, 8'h00, 1'b0, 5'd0);
        send_item(OP_READ, 2'd0, 8'h00, 1'b0, 5'd0);
        send_item(OP_READ, 2'd0, 8'h00, 1'b0, 5'd0);
        send_item(OP_WRITE, PORT_CTRL, 8'hAA, 1'b0, 5'd0);
        send_item(OP_WRITE, 2'd2, 8'hFF, 1'b0, 5'd0);
        send_item(OP_GATE, 2'd2, 8'h00, 1'b1, 5'd0);
        send_item(OP_TICK, 2'd0, 8'h00, 1'b0, 5'd1);
        drain();

        // Random part, with full drains near the halfway mark.
        items_sent = 0;
        while (items_sent < 600) begin
            random_sequence();
            if (items_sent >= 300 && items_sent < 305) drain();
        end
        drain();
        repeat (64) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("interval_timer_three_channel_unit_test: done, clean");
        end else begin
            $display("interval_timer_three_channel_unit_test: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/itt_pkg.sv
rtl/core/itt_ctrl.sv
rtl/core/itt_dp.sv
rtl/core/interval_timer_three_channel_unit.sv
sim/interval_timer_three_channel_unit_test.sv
